// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Hold an invariant at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("invariant violated");

// Require the consequent in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");

// Require the consequent in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/ord_pkg.sv =====
// ----------------------------------------------------------------------------
// ord_pkg
// Types and constants shared by the output-restricted deque modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ord_pkg;

	localparam int VALUE_BITS        = 64;
	localparam int OP_BITS           = 2;
	localparam int STATUS_BITS       = 2;
	localparam int DEPTH_DEFAULT     = 64;
	localparam int WORD_BITS_DEFAULT = 64;

	// Command queue between front and back.
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	typedef enum logic [OP_BITS-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_DUMP       = 2'd3
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Classified command handed from front to back.
	typedef struct packed {
		logic                  insert;
		logic                  at_front;
		logic                  dump;
		logic [VALUE_BITS-1:0] value;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_READ
	} bk_state_t;

endpackage

// ===== rtl/ord_ram.sv =====
// ----------------------------------------------------------------------------
// ord_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ord_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/ord_front.sv =====
// ----------------------------------------------------------------------------
// ord_front
// Input stage: take a word, decode the opcode, register the command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ord_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ord_pkg::OP_BITS-1:0]    in_op,
	input  logic [ord_pkg::VALUE_BITS-1:0] in_value,
	output logic                           cmd_valid,
	input  logic                           cmd_ready,
	output ord_pkg::cmd_t                  cmd
);

	logic          valid_s1;
	ord_pkg::cmd_t cmd_s1;
	ord_pkg::cmd_t decoded;
	ord_pkg::op_t  op;

	assign op = ord_pkg::op_t'(in_op);

	always_comb begin
		decoded.insert   = 1'b0;
		decoded.at_front = 1'b0;
		decoded.dump     = 1'b0;
		decoded.value    = in_value;
		case (op)
			ord_pkg::OP_PUSH_FRONT: begin
				decoded.insert   = 1'b1;
				decoded.at_front = 1'b1;
			end
			ord_pkg::OP_PUSH_REAR: begin
				decoded.insert = 1'b1;
			end
			ord_pkg::OP_POP_FRONT: begin
				decoded.at_front = 1'b1;
			end
			ord_pkg::OP_DUMP: begin
				decoded.dump = 1'b1;
			end
			default: begin
				decoded.dump = 1'b0;
			end
		endcase
	end

	// Accept whenever the stage is empty or drains this cycle.
	assign in_ready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= decoded;
		end
	end

endmodule

// ===== rtl/ord_cmdq.sv =====
// ----------------------------------------------------------------------------
// ord_cmdq
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ord_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  ord_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output ord_pkg::cmd_t pop_cmd
);

	ord_pkg::cmd_t                    entry_q [ord_pkg::CMDQ_DEPTH];
	logic [ord_pkg::CMDQ_PTR_W-1:0]   wr_ptr_q;
	logic [ord_pkg::CMDQ_PTR_W-1:0]   rd_ptr_q;
	logic [ord_pkg::CMDQ_CNT_W-1:0]   fill_q;
	logic                             push;
	logic                             pop;

	function automatic logic [ord_pkg::CMDQ_PTR_W-1:0] ptr_next(
		input logic [ord_pkg::CMDQ_PTR_W-1:0] p
	);
		ptr_next = (p == ord_pkg::CMDQ_PTR_W'(ord_pkg::CMDQ_DEPTH - 1)) ?
			'0 : ord_pkg::CMDQ_PTR_W'(p + 1'b1);
	endfunction

	assign push_ready = (fill_q != ord_pkg::CMDQ_CNT_W'(ord_pkg::CMDQ_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= ord_pkg::CMDQ_CNT_W'(fill_q + 1'b1);
			end else if (pop && !push) begin
				fill_q <= ord_pkg::CMDQ_CNT_W'(fill_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	`ASSERT_ALWAYS(a_fill_range, clk, arst_n, fill_q <= ord_pkg::CMDQ_CNT_W'(ord_pkg::CMDQ_DEPTH))

endmodule

// ===== rtl/ord_back.sv =====
// ----------------------------------------------------------------------------
// ord_back
// Execution side: ring indices, word store, dump walk and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ord_back #(
	parameter int DEPTH     = ord_pkg::DEPTH_DEFAULT,
	parameter int WORD_BITS = ord_pkg::WORD_BITS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  ord_pkg::cmd_t                   cmd,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ord_pkg::STATUS_BITS-1:0] out_status,
	output logic [ord_pkg::VALUE_BITS-1:0]  out_data,
	output logic                            out_last
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ord_pkg::bk_state_t state_q, state_d;

	logic [IDX_W-1:0] head_q, tail_q, walk_q;
	logic [CNT_W-1:0] count_q, left_q;

	logic                  out_valid_q;
	ord_pkg::status_t      out_status_q;
	logic [ord_pkg::VALUE_BITS-1:0] out_data_q;
	logic                  out_last_q;

	logic                  out_free, full, empty;
	logic                  we, rd_en;
	logic [IDX_W-1:0]      waddr, raddr, ins_addr;
	logic [WORD_BITS-1:0]  rdata;
	logic                  load, ld_last;
	ord_pkg::status_t      ld_status;
	logic [ord_pkg::VALUE_BITS-1:0] ld_data;
	logic                  start_walk, step_walk, do_ins, do_rm;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		ring_next = (i == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(i + 1'b1);
	endfunction

	function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
		ring_prev = (i == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(i - 1'b1);
	endfunction

	assign out_free = !out_valid_q || out_ready;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign ins_addr = empty ? '0 : (cmd.at_front ? ring_prev(head_q) : ring_next(tail_q));

	ord_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (cmd.value[WORD_BITS-1:0]),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ord_pkg::BK_IDLE: begin
				if (cmd_valid && !cmd.insert && !empty) begin
					state_d = ord_pkg::BK_READ;
				end
			end
			ord_pkg::BK_READ: begin
				if (out_free && left_q == '0) begin
					state_d = ord_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = ord_pkg::BK_IDLE;
			end
		endcase
	end

	// Strobes and result fields.
	always_comb begin
		cmd_ready  = 1'b0;
		rd_en      = 1'b0;
		raddr      = head_q;
		we         = 1'b0;
		waddr      = ins_addr;
		load       = 1'b0;
		ld_status  = ord_pkg::ST_OK;
		ld_data    = '0;
		ld_last    = 1'b1;
		start_walk = 1'b0;
		step_walk  = 1'b0;
		do_ins     = 1'b0;
		do_rm      = 1'b0;
		case (state_q)
			ord_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					if (cmd.insert) begin
						if (out_free) begin
							cmd_ready = 1'b1;
							load      = 1'b1;
							if (full) begin
								ld_status = ord_pkg::ST_FULL;
							end else begin
								we     = 1'b1;
								do_ins = 1'b1;
							end
						end
					end else if (empty) begin
						if (out_free) begin
							cmd_ready = 1'b1;
							load      = 1'b1;
							ld_status = ord_pkg::ST_EMPTY;
						end
					end else begin
						// Read the front word; a remove retires it now.
						cmd_ready  = 1'b1;
						rd_en      = 1'b1;
						start_walk = 1'b1;
						do_rm      = !cmd.dump;
					end
				end
			end
			ord_pkg::BK_READ: begin
				if (out_free) begin
					load    = 1'b1;
					ld_data = ord_pkg::VALUE_BITS'(rdata);
					ld_last = (left_q == '0);
					if (left_q != '0) begin
						rd_en     = 1'b1;
						raddr     = walk_q;
						step_walk = 1'b1;
					end
				end
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ord_pkg::BK_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			walk_q  <= '0;
			left_q  <= '0;
		end else begin
			state_q <= state_d;
			if (do_ins) begin
				if (empty) begin
					head_q <= '0;
					tail_q <= '0;
				end else if (cmd.at_front) begin
					head_q <= ring_prev(head_q);
				end else begin
					tail_q <= ring_next(tail_q);
				end
				count_q <= CNT_W'(count_q + 1'b1);
			end
			if (do_rm) begin
				if (count_q != CNT_W'(1)) begin
					head_q <= ring_next(head_q);
				end
				count_q <= CNT_W'(count_q - 1'b1);
			end
			if (start_walk) begin
				walk_q <= ring_next(head_q);
				left_q <= cmd.dump ? CNT_W'(count_q - 1'b1) : '0;
			end else if (step_walk) begin
				walk_q <= ring_next(walk_q);
				left_q <= CNT_W'(left_q - 1'b1);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= ld_status;
			out_data_q   <= ld_data;
			out_last_q   <= ld_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_data   = out_data_q;
	assign out_last   = out_last_q;

	`ASSERT_ALWAYS(a_count_range, clk, arst_n, count_q <= CNT_W'(DEPTH))
	`ASSERT_ALWAYS(a_no_rw_clash, clk, arst_n, !(we && rd_en))
	`ASSERT_IMPLIES(a_walk_bounded, clk, arst_n, state_q == ord_pkg::BK_READ, left_q < CNT_W'(DEPTH))
	`ASSERT_NEXT(a_empty_answer, clk, arst_n, state_q == ord_pkg::BK_IDLE && cmd_valid && !cmd.insert && empty && out_free, out_valid_q && out_status_q == ord_pkg::ST_EMPTY)

endmodule

// ===== rtl/output_restricted_deque.sv =====
// ----------------------------------------------------------------------------
// output_restricted_deque
// Output-restricted deque on a circular word store with a streaming interface.
// ----------------------------------------------------------------------------
// Each input word carries an opcode in s_axis_tuser (insert at front, insert
// at rear, remove from front, dump) and a data value in s_axis_tdata. Every
// input word produces at least one result word: inserts answer ok or full,
// removes answer the front word or empty, and a dump streams every held word
// from front to rear with tlast on the final one (or one empty answer). Only
// the low WORD_BITS bits of a value are stored; result data is zero-extended.
// A front stage decodes the opcode and feeds a two-entry command queue, so
// the input side keeps taking words while the back end works or the output
// is stalled, until the front register and the queue are full. At the back
// end, an insert or an empty/full answer is loaded straight from the idle
// state, a remove reads the front word from the registered store and then
// presents it, and a dump presents each held word in turn while reading the
// next, all through the single read port of the store; no new command is
// taken until a remove or dump has presented its last word, and any result
// waits while the output is stalled. A result passes the front register,
// the queue and the result register, plus the store read register for a
// remove or a dump. There is no clearing pass after reset: the store is only
// read at slots that were written since the last insert into an empty deque.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module output_restricted_deque #(
	parameter int DEPTH     = ord_pkg::DEPTH_DEFAULT,
	parameter int WORD_BITS = ord_pkg::WORD_BITS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input words.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [ord_pkg::VALUE_BITS-1:0]  s_axis_tdata,  // [63:0] value
	input  logic [ord_pkg::OP_BITS-1:0]     s_axis_tuser,  // [1:0] op
	// Result words.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [ord_pkg::VALUE_BITS-1:0]  m_axis_tdata,  // [63:0] data
	output logic [ord_pkg::STATUS_BITS-1:0] m_axis_tuser,  // [1:0] status
	output logic                            m_axis_tlast
);

	// Front stage to command queue.
	logic          fr_valid, fr_ready;
	ord_pkg::cmd_t fr_cmd;

	// Command queue to back end.
	logic          bk_valid, bk_ready;
	ord_pkg::cmd_t bk_cmd;

	// Decode the opcode and register the command.
	ord_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_value  (s_axis_tdata),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready),
		.cmd       (fr_cmd)
	);

	// Hold commands while the back end walks a dump or waits on the output.
	ord_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_cmd   (fr_cmd),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_cmd    (bk_cmd)
	);

	// Execute against the ring store and drive the result register.
	ord_back #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (bk_valid),
		.cmd_ready  (bk_ready),
		.cmd        (bk_cmd),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_data   (m_axis_tdata),
		.out_last   (m_axis_tlast)
	);

endmodule
